/* rtl/sdr_pkg.sv */
package sdr_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 2;
  localparam int BIN_W       = 15;
  localparam int DELAY_W     = 24;
  localparam int SIZE_W      = 5;
  localparam int CFG_W       = 24;
  localparam int IDX_W       = 2;

  // Parameter defaults
  localparam int DEF_PHASE_BITS    = 16;
  localparam int DEF_MAX_SIZE_LOG2 = 16;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SIZE_LOG2  = 2'd0;
  localparam logic [IDX_W-1:0] REG_DELAY_Q8   = 2'd1;
  localparam logic [IDX_W-1:0] REG_SPIKE_MODE = 2'd2;

  // Reset values
  localparam logic [SIZE_W-1:0]  RST_SIZE_LOG2 = 5'd10;
  localparam logic [DELAY_W-1:0] RST_DELAY_Q8  = '0;

  // 2*pi in Q4.60
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  typedef struct packed {
    logic [BIN_W-1:0]              bin_index;
    logic signed [SAMPLE_BITS-1:0] real_in;
    logic signed [SAMPLE_BITS-1:0] imag_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] real_out;
    logic signed [SAMPLE_BITS-1:0] imag_out;
    logic                          clipped;
  } out_t;

  // Series term divide, small constant divisors only
  function automatic logic [63:0] div_small(input logic [63:0] t, input int n);
    logic [63:0] q;
    case (n)
      2:  q = t / 64'd2;   3:  q = t / 64'd3;   4:  q = t / 64'd4;   5:  q = t / 64'd5;
      6:  q = t / 64'd6;   7:  q = t / 64'd7;   8:  q = t / 64'd8;   9:  q = t / 64'd9;
      10: q = t / 64'd10;  11: q = t / 64'd11;  12: q = t / 64'd12;  13: q = t / 64'd13;
      14: q = t / 64'd14;  15: q = t / 64'd15;  16: q = t / 64'd16;  17: q = t / 64'd17;
      18: q = t / 64'd18;  19: q = t / 64'd19;  20: q = t / 64'd20;  21: q = t / 64'd21;
      22: q = t / 64'd22;  23: q = t / 64'd23;  24: q = t / 64'd24;  25: q = t / 64'd25;
      26: q = t / 64'd26;  27: q = t / 64'd27;  28: q = t / 64'd28;  29: q = t / 64'd29;
      30: q = t / 64'd30;
      default: q = t;
    endcase
    return q;
  endfunction

  // Quarter-wave table entry for offset r: {sin[31:0], cos[31:0]}, each a
  // rounded magnitude with fbits fraction bits. Elaboration only.
  function automatic logic [63:0] sincos_entry(input int pbits, input int fbits,
                                               input logic [31:0] r);
    logic [127:0]       w;
    logic [63:0]        a;
    logic [63:0]        term;
    logic signed [63:0] sv;
    logic signed [63:0] cv;
    logic [63:0]        s0;
    logic [63:0]        c0;
    int                 n;
    int                 sh;
    w    = 128'(TWO_PI_Q60) * 128'(r);
    a    = 64'(w >> pbits);
    sv   = $signed(a);
    cv   = $signed(64'd1 << 60);
    term = a;
    for (n = 2; n <= 30; n++) begin
      w    = 128'(term) * 128'(a);
      term = div_small(64'(w >> 60), n);
      case (n % 4)
        0:       cv = cv + $signed(term);
        1:       sv = sv + $signed(term);
        2:       cv = cv - $signed(term);
        default: sv = sv - $signed(term);
      endcase
    end
    sh = 60 - fbits;
    if (sv < 0) sv = '0;
    if (cv < 0) cv = '0;
    s0 = (64'(sv) + (64'd1 << (sh - 1))) >> sh;
    c0 = (64'(cv) + (64'd1 << (sh - 1))) >> sh;
    return {s0[31:0], c0[31:0]};
  endfunction

endpackage

/* rtl/spectral_delay_rotator_core.sv */
// Spectral delay rotator: rotates one packed real-FFT bin per word by the
// phase -2*pi*delay*k/N, or emits the bare phasor in spike mode.
// Input: a word is taken on a rising edge with start high and busy low.
//   busy is high only while rst is asserted; otherwise a word may enter
//   every cycle, back to back, with no gaps.
// Output: each result word is shown on result for exactly one cycle with
//   done high. The receiver cannot stall; results are never held.
// Pipeline: the word passes seven register stages, the first loaded at the
//   accepting edge: phase multiply, phase shift, quarter-wave ROM, quadrant
//   fold, rotation multiply, round add, saturate; done rises with the last.
//   Throughput is one word per clock, set by the single ROM read port and the
//   four product multipliers.
// Bin 0 carries DC in real and Nyquist in imag: in rotate mode DC passes,
//   Nyquist is scaled by the cosine of the Nyquist phase.
// Config: wr_en/wr_index/wr_data write size_log2, delay_q8, spike_mode;
//   write only while no word is in flight.
// Reset (synchronous, rst high) restores size_log2 = 10, delay 0, rotate
//   mode, and drops every word in flight.
module spectral_delay_rotator_core #(
  parameter int PHASE_BITS    = sdr_pkg::DEF_PHASE_BITS,
  parameter int MAX_SIZE_LOG2 = sdr_pkg::DEF_MAX_SIZE_LOG2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  sdr_pkg::in_t              item,
  output logic                      done,
  output sdr_pkg::out_t             result,
  input  logic                      wr_en,
  input  logic [sdr_pkg::IDX_W-1:0] wr_index,
  input  logic [sdr_pkg::CFG_W-1:0] wr_data
);
  import sdr_pkg::*;

  localparam int SW    = SAMPLE_BITS;
  localparam int EW    = FRAC_BITS + 1;                 // table magnitude width
  localparam int QTW   = PHASE_BITS - 2;                // quarter-wave address
  localparam int QDEPTH = 1 << QTW;
  localparam int KW    = (MAX_SIZE_LOG2 > BIN_W) ? MAX_SIZE_LOG2 : BIN_W;
  localparam int PRW   = DELAY_W + KW + 1;              // delay * k
  localparam int UW    = 8 + MAX_SIZE_LOG2;             // phase source bits
  localparam int PW    = 2 * SW;                        // product width
  localparam int SUMW  = PW + 1;
  localparam int QW    = SUMW - FRAC_BITS;              // after rounding shift
  localparam logic [SIZE_W-1:0] LG_MIN = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] LG_MAX = SIZE_W'(MAX_SIZE_LOG2);
  localparam logic signed [SUMW-1:0] HALF = SUMW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] ONE_Q = SW'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0]         size_log2;
  logic signed [DELAY_W-1:0] delay_q8;
  logic                      spike_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2  <= RST_SIZE_LOG2;
      delay_q8   <= RST_DELAY_Q8;
      spike_mode <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_SIZE_LOG2:  size_log2  <= wr_data[SIZE_W-1:0];
        REG_DELAY_Q8:   delay_q8   <= wr_data[DELAY_W-1:0];
        REG_SPIKE_MODE: spike_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Clamp size to the supported range
  logic [SIZE_W-1:0] lg;
  assign lg = (size_log2 < LG_MIN) ? LG_MIN :
              (size_log2 > LG_MAX) ? LG_MAX : size_log2;

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------
  // Quarter-wave sine/cosine ROM, both values per entry from one series
  // ---------------------------------------------------------------------
  logic [2*EW-1:0] rom [QDEPTH];

  for (genvar g = 0; g < QDEPTH; g++) begin : g_rom
    localparam logic [63:0] ENT = sincos_entry(PHASE_BITS, FRAC_BITS, 32'(g));
    assign rom[g] = {ENT[32+EW-1:32], ENT[EW-1:0]};
  end

  // ---------------------------------------------------------------------
  // Stage 1: bin number (Nyquist for bin 0) times delay
  // ---------------------------------------------------------------------
  logic                  v1;
  logic                  bin0_1;
  logic signed [PRW-1:0] prod1;
  logic signed [SW-1:0]  re1, im1;
  logic                  bin0_in;
  logic [KW-1:0]         k_in;

  assign bin0_in = (item.bin_index == '0);
  assign k_in    = bin0_in ? (KW'(1) << (lg - SIZE_W'(1))) : KW'(item.bin_index);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= accept;
  end

  always_ff @(posedge clk) begin
    prod1  <= PRW'(delay_q8) * PRW'($signed({1'b0, k_in}));
    bin0_1 <= bin0_in;
    re1    <= item.real_in;
    im1    <= item.imag_in;
  end

  // ---------------------------------------------------------------------
  // Stage 2: negate and take the phase word, floor to PHASE_BITS turns
  // ---------------------------------------------------------------------
  logic                       v2;
  logic                       bin0_2;
  logic [PHASE_BITS-1:0]      phase2;
  logic signed [SW-1:0]       re2, im2;
  logic [UW-1:0]              negp;
  logic [UW+PHASE_BITS-1:0]   negp_ext;
  logic [SIZE_W:0]            shamt;

  assign negp     = UW'(-prod1);
  assign negp_ext = {negp, {PHASE_BITS{1'b0}}};
  assign shamt    = (SIZE_W+1)'(8) + {1'b0, lg};

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    phase2 <= PHASE_BITS'(negp_ext >> shamt);
    bin0_2 <= bin0_1;
    re2    <= re1;
    im2    <= im1;
  end

  // ---------------------------------------------------------------------
  // Stage 3: ROM read
  // ---------------------------------------------------------------------
  logic                 v3;
  logic                 bin0_3;
  logic [1:0]           quad3;
  logic [2*EW-1:0]      rom_q;
  logic signed [SW-1:0] re3, im3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    rom_q  <= rom[phase2[QTW-1:0]];
    quad3  <= phase2[PHASE_BITS-1:PHASE_BITS-2];
    bin0_3 <= bin0_2;
    re3    <= re2;
    im3    <= im2;
  end

  // ---------------------------------------------------------------------
  // Stage 4: fold quadrant into signed sine/cosine
  // ---------------------------------------------------------------------
  logic                 v4;
  logic                 bin0_4;
  logic signed [SW-1:0] s4, c4, re4, im4;
  logic signed [SW-1:0] s_q, c_q, s_next, c_next;

  assign s_q = $signed({1'b0, rom_q[2*EW-1:EW]});
  assign c_q = $signed({1'b0, rom_q[EW-1:0]});

  always_comb begin
    case (quad3)
      2'd0:    begin s_next = s_q;  c_next = c_q;  end
      2'd1:    begin s_next = c_q;  c_next = -s_q; end
      2'd2:    begin s_next = -s_q; c_next = -c_q; end
      default: begin s_next = -c_q; c_next = s_q;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end

  always_ff @(posedge clk) begin
    s4     <= s_next;
    c4     <= c_next;
    bin0_4 <= bin0_3;
    re4    <= re3;
    im4    <= im3;
  end

  // ---------------------------------------------------------------------
  // Stage 5: four rotation products
  // ---------------------------------------------------------------------
  logic                 v5;
  logic                 bin0_5;
  logic signed [PW-1:0] p_rc, p_is, p_rs, p_ic;
  logic signed [SW-1:0] s5, c5, re5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
  end

  always_ff @(posedge clk) begin
    p_rc   <= PW'(re4) * PW'(c4);
    p_is   <= PW'(im4) * PW'(s4);
    p_rs   <= PW'(re4) * PW'(s4);
    p_ic   <= PW'(im4) * PW'(c4);
    s5     <= s4;
    c5     <= c4;
    re5    <= re4;
    bin0_5 <= bin0_4;
  end

  // ---------------------------------------------------------------------
  // Stage 6: sums with round-half-up constant
  // ---------------------------------------------------------------------
  logic                   v6;
  logic                   bin0_6;
  logic signed [SUMW-1:0] sum_r, sum_i;
  logic signed [SW-1:0]   s6, c6, re6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
  end

  always_ff @(posedge clk) begin
    sum_r  <= SUMW'(p_rc) - SUMW'(p_is) + HALF;
    sum_i  <= bin0_5 ? (SUMW'(p_ic) + HALF) : (SUMW'(p_rs) + SUMW'(p_ic) + HALF);
    s6     <= s5;
    c6     <= c5;
    re6    <= re5;
    bin0_6 <= bin0_5;
  end

  // ---------------------------------------------------------------------
  // Stage 7: floor shift, saturate, select the output word
  // ---------------------------------------------------------------------
  function automatic logic [SW:0] saturate(input logic [QW-1:0] q);
    logic [QW-SW:0] top;
    logic           ok;
    top = q[QW-1:SW-1];
    ok  = (&top) || !(|top);
    if (ok) return {1'b0, q[SW-1:0]};
    return {1'b1, (q[QW-1] ? SAT_MIN : SAT_MAX)};
  endfunction

  logic [SW:0] sat_r, sat_i;
  out_t        out_next;

  assign sat_r = saturate(sum_r[SUMW-1:FRAC_BITS]);
  assign sat_i = saturate(sum_i[SUMW-1:FRAC_BITS]);

  always_comb begin
    if (spike_mode) begin
      out_next.real_out = bin0_6 ? ONE_Q : c6;
      out_next.imag_out = bin0_6 ? c6 : s6;
      out_next.clipped  = 1'b0;
    end else if (bin0_6) begin
      out_next.real_out = re6;
      out_next.imag_out = $signed(sat_i[SW-1:0]);
      out_next.clipped  = sat_i[SW];
    end else begin
      out_next.real_out = $signed(sat_r[SW-1:0]);
      out_next.imag_out = $signed(sat_i[SW-1:0]);
      out_next.clipped  = sat_r[SW] | sat_i[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v6;
  end

  always_ff @(posedge clk) begin
    result <= out_next;
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // Every result word traces back to an accepted input word.
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 7))
    else $error("result word without an accepted input word");

  // Zero delay is a unit rotation: ordinary bins pass through untouched.
  a_zero_delay_pass: assert property (@(posedge clk) disable iff (rst)
    done && !spike_mode && $past(delay_q8 == '0 && item.bin_index != '0, 7)
    |-> result.real_out == $past(item.real_in, 7) &&
        result.imag_out == $past(item.imag_in, 7) && !result.clipped)
    else $error("zero delay did not pass the bin through");

  // Outside spike mode, DC in bin 0 is never rotated or scaled.
  a_dc_pass: assert property (@(posedge clk) disable iff (rst)
    done && !spike_mode && $past(item.bin_index == '0, 7)
    |-> result.real_out == $past(item.real_in, 7))
    else $error("DC value altered");

endmodule
